// File: rtl/core/json_string_unescape_macros.svh
// Assertion macros for the string unescape RTL, used by the back end.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("json_string_unescape: same-cycle check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("json_string_unescape: next-cycle check failed");

`endif

// File: rtl/core/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescape block.
package jsu_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
   localparam logic [2:0] ERR_CONTROL   = 3'd2;
   localparam logic [2:0] ERR_ESCAPE    = 3'd3;
   localparam logic [2:0] ERR_HEX       = 3'd4;
   localparam logic [2:0] ERR_SURROGATE = 3'd5;
   localparam logic [2:0] ERR_EARLY     = 3'd6;

   // Input mode codes
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_END  = 1'b1;

   // Byte codes
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;

   // UTF-8 lead and continuation prefixes
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // Results per input word and default queue depth
   localparam int MAX_RESULTS         = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [2:0] error_code;
   } result_type;

   // One entry: the results caused by one input word
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } entry_type;

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [7:0] data,
                                              input logic [2:0] err);
      result_type r;
      r.kind       = kind;
      r.data_byte  = data;
      r.error_code = err;
      return r;
   endfunction

endpackage

// File: rtl/core/jsu_front.sv
// Front end: parses input words and packs their results into one queue entry.
module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       mode,
   input  logic [7:0] byte_value,
   input  logic       q_full,
   output logic       q_wr,
   output entry_type  q_wdata
);

   typedef enum logic [1:0] {PH_IDLE, PH_STRING, PH_ESCAPE, PH_HEX} phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] cp_ff, cp_in;
   logic [1:0]  seen_ff, seen_in;
   logic        accept;
   logic [4:0]  hex_val;
   logic [15:0] cp_next;
   entry_type   ent;

   // Map a hex digit to its value; bit 4 flags a non-hex byte
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
      return v;
   endfunction

   assign accept  = push & ~q_full;
   assign hex_val = hex_decode(byte_value);
   assign cp_next = {cp_ff[11:0], hex_val[3:0]};

   // Decode one word: next parse state and the results it causes
   always_comb begin
      phase_in = phase_ff;
      cp_in    = cp_ff;
      seen_in  = seen_ff;
      ent      = '0;
      case (phase_ff)
         PH_STRING: begin
            if (mode == MODE_END) begin
               phase_in = PH_IDLE;
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_EARLY);
            end else if (byte_value == CH_QUOTE) begin
               phase_in = PH_IDLE;
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_DONE, 8'h00, ERR_NONE);
            end else if (byte_value < CH_SPACE) begin
               phase_in = PH_IDLE;
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_CONTROL);
            end else if (byte_value == CH_BACKSLASH) begin
               phase_in = PH_ESCAPE;
            end else begin
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_BYTE, byte_value, ERR_NONE);
            end
         end
         PH_ESCAPE: begin
            ent.count = 2'd1;
            phase_in  = PH_STRING;
            if (mode == MODE_END) begin
               phase_in   = PH_IDLE;
               ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_EARLY);
            end else if (byte_value == CH_QUOTE || byte_value == CH_BACKSLASH ||
                         byte_value == CH_SLASH) begin
               ent.res[0] = make_result(KIND_BYTE, byte_value, ERR_NONE);
            end else if (byte_value == CH_LOWER_B) begin
               ent.res[0] = make_result(KIND_BYTE, CH_BACKSPACE, ERR_NONE);
            end else if (byte_value == CH_LOWER_F) begin
               ent.res[0] = make_result(KIND_BYTE, CH_FORMFEED, ERR_NONE);
            end else if (byte_value == CH_LOWER_N) begin
               ent.res[0] = make_result(KIND_BYTE, CH_LF, ERR_NONE);
            end else if (byte_value == CH_LOWER_R) begin
               ent.res[0] = make_result(KIND_BYTE, CH_CR, ERR_NONE);
            end else if (byte_value == CH_LOWER_T) begin
               ent.res[0] = make_result(KIND_BYTE, CH_TAB, ERR_NONE);
            end else if (byte_value == CH_LOWER_U) begin
               ent.count = 2'd0;
               phase_in  = PH_HEX;
               cp_in     = '0;
               seen_in   = '0;
            end else begin
               phase_in   = PH_IDLE;
               ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_ESCAPE);
            end
         end
         PH_HEX: begin
            if (mode == MODE_END || hex_val[4]) begin
               phase_in   = PH_IDLE;
               cp_in      = '0;
               seen_in    = '0;
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_ERROR, 8'h00,
                                        (mode == MODE_END) ? ERR_EARLY : ERR_HEX);
            end else if (seen_ff != 2'd3) begin
               cp_in   = cp_next;
               seen_in = seen_ff + 2'd1;
            end else begin
               // Fourth digit: range check, then UTF-8 encode
               cp_in   = '0;
               seen_in = '0;
               if (cp_next[15:11] == 5'b11011) begin
                  phase_in   = PH_IDLE;
                  ent.count  = 2'd1;
                  ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_SURROGATE);
               end else if (cp_next[15:7] == '0) begin
                  phase_in   = PH_STRING;
                  ent.count  = 2'd1;
                  ent.res[0] = make_result(KIND_BYTE, cp_next[7:0], ERR_NONE);
               end else if (cp_next[15:11] == '0) begin
                  phase_in   = PH_STRING;
                  ent.count  = 2'd2;
                  ent.res[0] = make_result(KIND_BYTE,
                                  UTF8_LEAD2 | {3'b000, cp_next[10:6]}, ERR_NONE);
                  ent.res[1] = make_result(KIND_BYTE,
                                  UTF8_CONT | {2'b00, cp_next[5:0]}, ERR_NONE);
               end else begin
                  phase_in   = PH_STRING;
                  ent.count  = 2'd3;
                  ent.res[0] = make_result(KIND_BYTE,
                                  UTF8_LEAD3 | {4'b0000, cp_next[15:12]}, ERR_NONE);
                  ent.res[1] = make_result(KIND_BYTE,
                                  UTF8_CONT | {2'b00, cp_next[11:6]}, ERR_NONE);
                  ent.res[2] = make_result(KIND_BYTE,
                                  UTF8_CONT | {2'b00, cp_next[5:0]}, ERR_NONE);
               end
            end
         end
         default: begin
            // Idle: skip whitespace, wait for the opening quote; other bytes and end are errors
            phase_in = PH_IDLE;
            cp_in    = '0;
            seen_in  = '0;
            if (mode == MODE_END) begin
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_NO_QUOTE);
            end else if (byte_value inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
               ent.count = 2'd0;
            end else if (byte_value == CH_QUOTE) begin
               phase_in = PH_STRING;
            end else begin
               ent.count  = 2'd1;
               ent.res[0] = make_result(KIND_ERROR, 8'h00, ERR_NO_QUOTE);
            end
         end
      endcase
   end

   // Push an entry only when the word caused results
   assign q_wr    = accept & (ent.count != 2'd0);
   assign q_wdata = ent;

   // Hold parse state; advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cp_ff    <= '0;
         seen_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cp_ff    <= cp_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// File: rtl/core/jsu_queue.sv
// Small entry queue between the front and back ends.
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr,
   input  entry_type wdata,
   input  logic      rd,
   output entry_type rdata,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr & ~full;
   assign do_rd = rd & ~empty;
   assign rdata = slots_ff[rptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      if (do_rd) rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (!do_wr && do_rd) count_in = count_ff - 1'b1;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_wr) slots_ff[wptr_ff] <= wdata;
   end

endmodule

// File: rtl/core/jsu_back.sv
// Back end: unpacks queued entries and hands out one result word per pop.
`include "json_string_unescape_macros.svh"
module jsu_back
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_rdata,
   output logic       q_rd,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   entry_type  cur_ff, cur_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       take, is_last, load;
   result_type res;

   assign res       = cur_ff.res[idx_ff];
   assign is_last   = (idx_ff == cur_ff.count - 2'd1);
   assign take      = valid_ff & rsp_pop;
   assign load      = (~valid_ff | (take & is_last)) & ~q_empty;
   assign q_rd      = load;

   // Drive the result ports from the held entry
   assign rsp_empty       = ~valid_ff;
   assign rsp_kind        = res.kind;
   assign rsp_data_byte   = res.data_byte;
   assign rsp_error_code  = res.error_code;
   assign rsp_last_of_run = is_last;

   // Load a new entry, advance within it, or drop it after its last word
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         cur_in   = q_rdata;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (take && is_last) begin
         valid_in = 1'b0;
         idx_in   = '0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `JSU_ASSERT_NOW(a_held_entry_nonempty, clock, reset, valid_ff, cur_ff.count != 2'd0)
   `JSU_ASSERT_NOW(a_index_in_entry, clock, reset, valid_ff, idx_ff < cur_ff.count)
   `JSU_ASSERT_NOW(a_read_only_when_ready, clock, reset, q_rd, !q_empty)
   `JSU_ASSERT_NEXT(a_load_starts_at_first, clock, reset, q_rd, valid_ff && idx_ff == 2'd0)

endmodule

// File: rtl/core/json_string_unescape.sv
// Top level of the streaming JSON string unescape block.
// Input channel (req_): one byte or an end-of-input marker per word. A word is
//   taken at a clock edge with req_push high and req_full low.
// Result channel (rsp_): decoded bytes, string-closed and error words. The oldest
//   word sits on the rsp_ ports while rsp_empty is low; rsp_pop takes it.
//   rsp_last_of_run marks the final word caused by one input word.
// The first result of an input word passes the entry queue and the result stage:
//   the front writes the queue at the edge that takes the word, and the back end
//   then loads the entry into its result stage, where it can be popped.
// Throughput: one input word per cycle while each causes at most one result
//   and the receiver keeps popping; a \u escape that encodes to two or three
//   UTF-8 bytes needs that many pops, which the back end hands out one per cycle.
// The entry queue between front and back (QUEUE_DEPTH entries) soaks up those
//   bursts; req_full rises only when it fills.
// A stalled receiver holds the current result on the ports; the front keeps
//   taking words until the queue is full.
// Reset (synchronous, active high) returns the parser to idle outside any
//   string and empties the queue and the result stage.
module json_string_unescape
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_mode,
   input  logic [7:0] req_byte_value,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_of_run
);

   logic      q_wr, q_rd, q_full, q_empty;
   entry_type q_wdata, q_rdata;

   assign req_full = q_full;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .mode       (req_mode),
      .byte_value (req_byte_value),
      .q_full     (q_full),
      .q_wr       (q_wr),
      .q_wdata    (q_wdata)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .rd    (q_rd),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_rdata         (q_rdata),
      .q_rd            (q_rd),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
